FILE: design/pwm_pkg.sv
// Shared types and constants of the phrase window match responder.
package pwm_pkg;

    localparam int WINDOW_LENGTH = 16;
    localparam int PHRASE_WIDTH  = 64;
    localparam int BYTE_WIDTH    = 8;
    localparam int REPLY_CNT_W   = 3;

    localparam logic [PHRASE_WIDTH-1:0] PHRASE_FIRST_RESET  = 64'h6E61_205E_2065_6874;
    localparam logic [PHRASE_WIDTH-1:0] PHRASE_SECOND_RESET = 64'h7379_656B_2076_2064;

    localparam logic [BYTE_WIDTH-1:0] REPLY_V  = 8'h76;
    localparam logic [BYTE_WIDTH-1:0] REPLY_CR = 8'h0D;

    localparam logic [REPLY_CNT_W-1:0] REPLY_LEN_HIGH = 3'd4;
    localparam logic [REPLY_CNT_W-1:0] REPLY_LEN_LOW  = 3'd1;

    localparam logic CFG_PHRASE_FIRST  = 1'b0;
    localparam logic CFG_PHRASE_SECOND = 1'b1;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] rx_byte;
        logic                  switch_high;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] reply_byte;
        logic                  reply_last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic switch_high;
    } t_reply_req;

endpackage

FILE: design/pwm_cell.sv
// One window cell: holds a byte, passes it to the older neighbor, flags a phrase hit.
module pwm_cell
    import pwm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic [BYTE_WIDTH-1:0] i_byte,
    input  logic [BYTE_WIDTH-1:0] i_phrase_char,
    output logic [BYTE_WIDTH-1:0] o_byte,
    output logic                  o_hit
);

    logic [BYTE_WIDTH-1:0] r_byte;
    logic                  r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_hit <= (i_byte == i_phrase_char);
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = r_hit;

endmodule

FILE: design/pwm_reply.sv
// Reply sequencer: plays out 'v','v','v',CR or CR alone, one byte per transfer.
module pwm_reply
    import pwm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_reply_req i_req,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_item  o_data
);

    logic [REPLY_CNT_W-1:0] r_cnt;
    logic [REPLY_CNT_W-1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_req.load) begin
            n_cnt = i_req.switch_high ? REPLY_LEN_HIGH : REPLY_LEN_LOW;
        end else if (o_valid && !i_stall) begin
            n_cnt = r_cnt - REPLY_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_free  = (r_cnt == '0) || ((r_cnt == REPLY_LEN_LOW) && !i_stall);
    assign o_data.reply_last = (r_cnt == REPLY_LEN_LOW);
    assign o_data.reply_byte = (r_cnt == REPLY_LEN_LOW) ? REPLY_CR : REPLY_V;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= REPLY_LEN_HIGH)
        else $error("reply count out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.load |-> o_free)
        else $error("reply loaded while busy");

    a_last_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.reply_last == (o_data.reply_byte == REPLY_CR)))
        else $error("last flag not on CR");

endmodule

FILE: design/phrase_window_match_responder.sv
// Top level: window cell chain, match stage and reply sequencer of the phrase responder.
//
// A received byte shifts into a chain of WINDOW_LENGTH cells (oldest at cell 0); each cell
// compares its new byte with its phrase character, and in the cycle after the transfer the
// AND of all cell hits decides the match; the reply count is then registered before the first
// reply byte can transfer. Bytes that do not match are taken one per cycle. A match waits only
// while the reply sequencer is still busy with an earlier reply, so matches in a row are taken
// one per reply, the next as the earlier one's CR transfers; one per cycle with the switch low
// if the output does not stall. The reply sequencer is the bound. The user must write the phrase
// registers through the cfg port only while the block is idle; the block does not enforce it.
module phrase_window_match_responder
    import pwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_item               o_out_data,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [PHRASE_WIDTH-1:0] i_cfg_data
);

    logic [PHRASE_WIDTH-1:0]   r_phrase_first;
    logic [PHRASE_WIDTH-1:0]   r_phrase_second;
    logic [2*PHRASE_WIDTH-1:0] w_phrase;

    logic                      r_s1_valid;
    logic                      r_s1_switch;
    logic                      w_accept;
    logic                      w_match;
    logic                      w_s1_leave;
    logic                      w_free;
    t_reply_req                w_req;

    logic [BYTE_WIDTH-1:0]     w_bytes [WINDOW_LENGTH+1];
    logic [WINDOW_LENGTH-1:0]  w_hits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phrase_first  <= PHRASE_FIRST_RESET;
            r_phrase_second <= PHRASE_SECOND_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PHRASE_FIRST: begin
                    r_phrase_first <= i_cfg_data;
                end
                CFG_PHRASE_SECOND: begin
                    r_phrase_second <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_phrase = {r_phrase_second, r_phrase_first};
    assign w_accept = i_in_valid && !o_in_stall;
    assign w_bytes[WINDOW_LENGTH] = i_in_data.rx_byte;

    for (genvar k = 0; k < WINDOW_LENGTH; k++) begin : g_cell
        pwm_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_shift       (w_accept),
            .i_byte        (w_bytes[k+1]),
            .i_phrase_char (w_phrase[BYTE_WIDTH*k +: BYTE_WIDTH]),
            .o_byte        (w_bytes[k]),
            .o_hit         (w_hits[k])
        );
    end

    assign w_match    = &w_hits;
    assign w_s1_leave = r_s1_valid && (!w_match || w_free);
    assign o_in_stall = r_s1_valid && !w_s1_leave;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_leave) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_switch <= i_in_data.switch_high;
        end
    end

    assign w_req.load        = w_s1_leave && w_match;
    assign w_req.switch_high = r_s1_switch;

    pwm_reply u_reply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_free  (w_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

    a_stall_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with empty match stage");

    a_hold_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_leave) |=> r_s1_valid)
        else $error("pending item lost");

    a_match_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_match && !w_free) |-> o_in_stall)
        else $error("match passed a busy reply sequencer");

endmodule

FILE: bench/tb.sv
// Testbench for the phrase window match responder: window predictor, reply checker, random flow.
module tb;
    import pwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RX_TARGET   = 440;

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_stall;
    t_in_item                i_in_data   = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    t_out_item               o_out_data;
    logic                    i_cfg_we    = 1'b0;
    logic                    i_cfg_index = CFG_PHRASE_FIRST;
    logic [PHRASE_WIDTH-1:0] i_cfg_data  = '0;

    phrase_window_match_responder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [BYTE_WIDTH-1:0]     rx_window [WINDOW_LENGTH] = '{default: '0};
    logic [2*PHRASE_WIDTH-1:0] phrase_text = {PHRASE_SECOND_RESET, PHRASE_FIRST_RESET};

    t_in_item  rx_pending [$];
    t_out_item replies_due [$];

    int mismatches  = 0;
    int cycle_count = 0;
    int rx_queued   = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    logic [5:0] stall_phase = '0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    // shift the byte into the window, oldest at 0, then compare with the phrase
    task automatic absorb_rx(input t_in_item it);
        logic hit;
        hit = 1'b1;
        for (int k = 0; k < WINDOW_LENGTH - 1; k++)
            rx_window[k] = rx_window[k+1];
        rx_window[WINDOW_LENGTH-1] = it.rx_byte;
        for (int k = 0; k < WINDOW_LENGTH; k++)
            if (rx_window[k] != phrase_text[k*BYTE_WIDTH +: BYTE_WIDTH])
                hit = 1'b0;
        if (hit) begin
            if (it.switch_high) begin
                repeat (3)
                    replies_due.push_back(t_out_item'{reply_byte: REPLY_V, reply_last: 1'b0});
            end
            replies_due.push_back(t_out_item'{reply_byte: REPLY_CR, reply_last: 1'b1});
        end
    endtask

    task automatic check_reply(input t_out_item got);
        t_out_item want;
        if (replies_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected reply byte %h last %b",
                                    got.reply_byte, got.reply_last));
            return;
        end
        want = replies_due.pop_front();
        if (got.reply_byte !== want.reply_byte)
            flag_mismatch($sformatf("reply_byte %h, want %h", got.reply_byte, want.reply_byte));
        if (got.reply_last !== want.reply_last)
            flag_mismatch($sformatf("reply_last %b, want %b", got.reply_last, want.reply_last));
    endtask

    // input driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid)
                absorb_rx(i_in_data);
            if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (rx_pending.size() != 0) begin
                i_in_data  <= rx_pending.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output monitor and stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                check_reply(o_out_data);
            stall_phase <= stall_phase + 1'b1;
            if (stall_phase == '0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: begin
                    i_out_stall <= 1'b0;
                end
                1: begin
                    i_out_stall <= 1'($urandom_range(0, 1));
                end
                2: begin
                    i_out_stall <= (stall_phase[2:0] < 3'd5);
                end
                default: begin
                    i_out_stall <= ($urandom_range(0, 4) == 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_rx(input logic [BYTE_WIDTH-1:0] b, input logic sw);
        rx_pending.push_back(t_in_item'{rx_byte: b, switch_high: sw});
        rx_queued++;
    endtask

    task automatic queue_phrase(input logic [2*PHRASE_WIDTH-1:0] text, input bit spoil);
        int bad;
        logic [BYTE_WIDTH-1:0] b;
        bad = spoil ? $urandom_range(0, WINDOW_LENGTH - 1) : -1;
        for (int k = 0; k < WINDOW_LENGTH; k++) begin
            b = text[k*BYTE_WIDTH +: BYTE_WIDTH];
            if (k == bad)
                b = b ^ 8'($urandom_range(1, 255));
            push_rx(b, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained(input int settle);
        do @(negedge i_clk);
        while (rx_pending.size() != 0 || i_in_valid || replies_due.size() != 0);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_phrase(input logic [PHRASE_WIDTH-1:0] first,
                                input logic [PHRASE_WIDTH-1:0] second);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PHRASE_FIRST;
        i_cfg_data  <= first;
        @(posedge i_clk);
        i_cfg_index <= CFG_PHRASE_SECOND;
        i_cfg_data  <= second;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        phrase_text = {second, first};
        @(negedge i_clk);
    endtask

    initial begin
        logic [PHRASE_WIDTH-1:0] first, second;
        logic [BYTE_WIDTH-1:0]   c;
        int phase_no;
        int kind;
        bit repeated;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fresh window: an all-zero phrase matches at once
        wait_drained(2);
        write_phrase('0, '0);
        push_rx(8'h00, 1'b1);
        push_rx(8'h00, 1'b0);
        push_rx(8'hFF, 1'b1);

        // default phrase sent whole, ending with the switch high
        wait_drained(8);
        write_phrase(PHRASE_FIRST_RESET, PHRASE_SECOND_RESET);
        queue_phrase({PHRASE_SECOND_RESET, PHRASE_FIRST_RESET}, 1'b0);
        rx_pending[$].switch_high = 1'b1;
        push_rx(8'hFF, 1'b0);

        phase_no = 0;
        while (rx_queued < RX_TARGET) begin
            kind     = $urandom_range(0, 9);
            repeated = (phase_no == 0) || (kind < 2);
            if (phase_no == 0)
                c = 8'hFF;
            else
                c = 8'($urandom_range(0, 255));
            if (repeated) begin
                first  = {8{c}};
                second = {8{c}};
            end else begin
                first  = {32'($urandom), 32'($urandom)};
                second = {32'($urandom), 32'($urandom)};
            end
            wait_drained(8);
            write_phrase(first, second);
            if (repeated) begin
                repeat ($urandom_range(16, 30)) push_rx(c, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 3))
                    push_rx(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(2, 4)) begin
                    repeat ($urandom_range(0, 3))
                        push_rx(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    queue_phrase({second, first}, $urandom_range(0, 5) == 0);
                end
            end
            phase_no++;
        end

        wait_drained(16);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
